[rtl/rcp_pkg.sv]
// Shared constants, types and codes of the raycast column projector.
`timescale 1ns / 1ps
package rcp_pkg;

   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;
   localparam int TEXTURE_WIDTH = 64;

   localparam int POS_W    = 22;
   localparam int DIR_W    = 16;
   localparam int COL_W    = 10;
   localparam int CELL_W   = 6;
   localparam int SIDE_W   = 2;
   localparam int CSR_W    = 22;
   localparam int CSR_IDX_W = 3;
   localparam int RAY_W    = 20;
   localparam int DIST_W   = 32;
   localparam int HEIGHT_W = 16;
   localparam int ROW_W    = 16;
   localparam int TEX_W    = 6;
   localparam int FRAC_W   = 16;

   localparam int SCAL_W   = COL_W + 3;
   localparam int PROD_W   = DIR_W + SCAL_W;
   localparam int BIAS_W   = 28;
   localparam int RX_SUM_W = BIAS_W + 2;
   localparam longint BIAS_M = ((64'd1 << 26) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
   localparam longint BIAS   = BIAS_M * SCREEN_WIDTH;
   localparam int RCP_K    = BIAS_W + $clog2(SCREEN_WIDTH);
   localparam longint RCP_M = ((64'd1 << RCP_K) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
   localparam int RCP_M_W  = BIAS_W + 1;
   localparam int MX_W     = BIAS_W + RCP_M_W;
   localparam int NUM_W    = POS_W + 2;

   localparam int DIV_N_W    = 40;
   localparam int DIV_D_W    = 32;
   localparam int DIV_STAGES = DIV_N_W;

   localparam logic [DIV_N_W-1:0] DELTA_NUM  = DIV_N_W'(64'd1 << 30);
   localparam logic [DIV_N_W-1:0] HEIGHT_NUM = DIV_N_W'(64'(SCREEN_HEIGHT) << 16);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_POS_X   = 3'd0,
      REG_POS_Y   = 3'd1,
      REG_DIR_X   = 3'd2,
      REG_DIR_Y   = 3'd3,
      REG_PLANE_X = 3'd4,
      REG_PLANE_Y = 3'd5
   } reg_index_type;

   typedef enum logic [SIDE_W-1:0] {
      SIDE_NORTH = 2'd0,
      SIDE_EAST  = 2'd1,
      SIDE_SOUTH = 2'd2,
      SIDE_WEST  = 2'd3
   } side_type;

   typedef struct packed {
      logic [POS_W-1:0]        pos_x;
      logic [POS_W-1:0]        pos_y;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic signed [DIR_W-1:0] plane_x;
      logic signed [DIR_W-1:0] plane_y;
   } cfg_type;

   typedef struct packed {
      logic                    neg_x;
      logic                    neg_y;
      logic                    zero_x;
      logic                    zero_y;
      logic                    zero_main;
      logic                    quot_neg;
      logic [SIDE_W-1:0]       side;
      logic signed [RAY_W-1:0] ray_other;
   } front_tag_type;

   typedef struct packed {
      logic [DIV_N_W-1:0] num_mag;
      logic [RAY_W-1:0]   main_mag;
      logic [RAY_W-1:0]   abs_x;
      logic [RAY_W-1:0]   abs_y;
      front_tag_type      tag;
   } ray_out_type;

   typedef struct packed {
      logic                     neg_x;
      logic                     neg_y;
      logic [DIST_W-1:0]        delta_x;
      logic [DIST_W-1:0]        delta_y;
      logic [DIST_W-1:0]        first_x;
      logic [DIST_W-1:0]        first_y;
      logic signed [DIST_W-1:0] wall_dist;
      logic                     height_max;
      logic                     height_zero;
      logic [TEX_W-1:0]         tex;
   } back_tag_type;

   localparam int DIV_TAG_W = $bits(back_tag_type);
   typedef logic [DIV_TAG_W-1:0] div_tag_type;

endpackage

[rtl/rcp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
`timescale 1ns / 1ps
module rcp_div import rcp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [DIV_N_W-1:0] in_dividend,
   input  logic [DIV_D_W-1:0] in_divisor,
   input  div_tag_type        in_tag,
   output logic               out_valid,
   output logic [DIV_N_W-1:0] out_quotient,
   output div_tag_type        out_tag
);

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_D_W-1:0]    rem_ff   [DIV_STAGES];
   logic [DIV_D_W-1:0]    rem_in   [DIV_STAGES];
   logic [DIV_D_W-1:0]    rem_src  [DIV_STAGES];
   logic [DIV_N_W-1:0]    work_ff  [DIV_STAGES];
   logic [DIV_N_W-1:0]    work_in  [DIV_STAGES];
   logic [DIV_N_W-1:0]    work_src [DIV_STAGES];
   logic [DIV_D_W-1:0]    dvs_ff   [DIV_STAGES];
   logic [DIV_D_W-1:0]    dvs_src  [DIV_STAGES];
   div_tag_type           tag_ff   [DIV_STAGES];
   div_tag_type           tag_src  [DIV_STAGES];
   logic [DIV_D_W:0]      trial    [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_src
      if (s == 0) begin : g_first
         assign rem_src[s]  = '0;
         assign work_src[s] = in_dividend;
         assign dvs_src[s]  = in_divisor;
         assign tag_src[s]  = in_tag;
      end else begin : g_next
         assign rem_src[s]  = rem_ff[s-1];
         assign work_src[s] = work_ff[s-1];
         assign dvs_src[s]  = dvs_ff[s-1];
         assign tag_src[s]  = tag_ff[s-1];
      end
   end

   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         trial[s] = {rem_src[s], work_src[s][DIV_N_W-1]};
         if (trial[s] >= {1'b0, dvs_src[s]}) begin
            rem_in[s]  = DIV_D_W'(trial[s] - {1'b0, dvs_src[s]});
            work_in[s] = {work_src[s][DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in[s]  = trial[s][DIV_D_W-1:0];
            work_in[s] = {work_src[s][DIV_N_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            rem_ff[s]  <= rem_in[s];
            work_ff[s] <= work_in[s];
            dvs_ff[s]  <= dvs_src[s];
            tag_ff[s]  <= tag_src[s];
         end
      end
   end

   assign out_valid    = valid_ff[DIV_STAGES-1];
   assign out_quotient = work_ff[DIV_STAGES-1];
   assign out_tag      = tag_ff[DIV_STAGES-1];

endmodule

[rtl/rcp_ray.sv]
// Ray direction, step signs and divider operands for one column.
`timescale 1ns / 1ps
module rcp_ray import rcp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  cfg_type           cfg,
   input  logic              in_valid,
   input  logic [COL_W-1:0]  in_col,
   input  logic [CELL_W-1:0] in_cell_x,
   input  logic [CELL_W-1:0] in_cell_y,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output ray_out_type       out_ray
);

   logic signed [SCAL_W-1:0]   scal;
   logic signed [PROD_W-1:0]   s1_nx_in, s1_ny_in, s1_nx_ff, s1_ny_ff;
   logic [CELL_W-1:0]          s1_cx_ff, s1_cy_ff, s2_cx_ff, s2_cy_ff, s3_cx_ff, s3_cy_ff;
   logic [SIDE_W-1:0]          s1_side_ff, s2_side_ff, s3_side_ff;
   logic signed [PROD_W-1:0]   xsum_x, xsum_y;
   logic [MX_W-1:0]            s2_mx_in, s2_my_in, s2_mx_ff, s2_my_ff;
   logic [MX_W-1:0]            shift_x, shift_y;
   logic signed [RX_SUM_W-1:0] rsum_x, rsum_y;
   logic signed [RAY_W-1:0]    s3_rx_ff, s3_ry_ff;
   logic                       neg_x, neg_y, xside, neg_main;
   logic signed [RAY_W-1:0]    ray_main;
   logic [CELL_W-1:0]          cell_sel;
   logic [POS_W-1:0]           pos_sel;
   logic signed [NUM_W-1:0]    num;
   logic [NUM_W-1:0]           num_mag;
   ray_out_type                s4_ray_in, s4_ray_ff;
   logic [3:0]                 valid_ff;

   assign scal     = $signed({2'b00, in_col, 1'b0}) - $signed(SCAL_W'(SCREEN_WIDTH));
   assign s1_nx_in = PROD_W'(cfg.plane_x) * PROD_W'(scal);
   assign s1_ny_in = PROD_W'(cfg.plane_y) * PROD_W'(scal);

   assign xsum_x   = s1_nx_ff + $signed(PROD_W'(BIAS));
   assign xsum_y   = s1_ny_ff + $signed(PROD_W'(BIAS));
   assign s2_mx_in = MX_W'(xsum_x[BIAS_W-1:0]) * MX_W'(RCP_M);
   assign s2_my_in = MX_W'(xsum_y[BIAS_W-1:0]) * MX_W'(RCP_M);

   assign shift_x = s2_mx_ff >> RCP_K;
   assign shift_y = s2_my_ff >> RCP_K;
   assign rsum_x  = RX_SUM_W'(cfg.dir_x) + $signed({2'b00, shift_x[BIAS_W-1:0]})
                    - $signed(RX_SUM_W'(BIAS_M));
   assign rsum_y  = RX_SUM_W'(cfg.dir_y) + $signed({2'b00, shift_y[BIAS_W-1:0]})
                    - $signed(RX_SUM_W'(BIAS_M));

   always_comb begin
      neg_x    = s3_rx_ff[RAY_W-1];
      neg_y    = s3_ry_ff[RAY_W-1];
      xside    = (s3_side_ff == SIDE_EAST) || (s3_side_ff == SIDE_WEST);
      ray_main = xside ? s3_rx_ff : s3_ry_ff;
      neg_main = ray_main[RAY_W-1];
      cell_sel = xside ? s3_cx_ff : s3_cy_ff;
      pos_sel  = xside ? cfg.pos_x : cfg.pos_y;
      num      = $signed(NUM_W'({cell_sel, 16'h0000})) - $signed(NUM_W'(pos_sel))
                 + $signed(NUM_W'(neg_main ? 17'h10000 : 17'h00000));
      num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

      s4_ray_in.num_mag       = DIV_N_W'({num_mag, 14'h0000});
      s4_ray_in.main_mag      = neg_main ? RAY_W'(-ray_main) : RAY_W'(ray_main);
      s4_ray_in.abs_x         = neg_x ? RAY_W'(-s3_rx_ff) : RAY_W'(s3_rx_ff);
      s4_ray_in.abs_y         = neg_y ? RAY_W'(-s3_ry_ff) : RAY_W'(s3_ry_ff);
      s4_ray_in.tag.neg_x     = neg_x;
      s4_ray_in.tag.neg_y     = neg_y;
      s4_ray_in.tag.zero_x    = (s3_rx_ff == '0);
      s4_ray_in.tag.zero_y    = (s3_ry_ff == '0);
      s4_ray_in.tag.zero_main = (ray_main == '0);
      s4_ray_in.tag.quot_neg  = num[NUM_W-1] ^ neg_main;
      s4_ray_in.tag.side      = s3_side_ff;
      s4_ray_in.tag.ray_other = xside ? s3_ry_ff : s3_rx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_nx_ff   <= s1_nx_in;
         s1_ny_ff   <= s1_ny_in;
         s1_cx_ff   <= in_cell_x;
         s1_cy_ff   <= in_cell_y;
         s1_side_ff <= in_side;
         s2_mx_ff   <= s2_mx_in;
         s2_my_ff   <= s2_my_in;
         s2_cx_ff   <= s1_cx_ff;
         s2_cy_ff   <= s1_cy_ff;
         s2_side_ff <= s1_side_ff;
         s3_rx_ff   <= rsum_x[RAY_W-1:0];
         s3_ry_ff   <= rsum_y[RAY_W-1:0];
         s3_cx_ff   <= s2_cx_ff;
         s3_cy_ff   <= s2_cy_ff;
         s3_side_ff <= s2_side_ff;
         s4_ray_ff  <= s4_ray_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_ray   = s4_ray_ff;

endmodule

[rtl/rcp_post.sv]
// Distance saturation, first-line distances and texture column after the first divide.
`timescale 1ns / 1ps
module rcp_post import rcp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  cfg_type            cfg,
   input  logic               in_valid,
   input  logic [DIV_N_W-1:0] in_quot_x,
   input  logic [DIV_N_W-1:0] in_quot_y,
   input  logic [DIV_N_W-1:0] in_quot_dist,
   input  front_tag_type      in_tag,
   output logic               out_valid,
   output logic [DIV_D_W-1:0] out_divisor,
   output back_tag_type       out_tag
);

   localparam int FP_W = FRAC_W + 1 + DIST_W;
   localparam int TP_W = DIST_W + RAY_W;

   logic [2:0]                 valid_ff;
   logic [DIST_W-1:0]          p1_dx_in, p1_dy_in, p1_dx_ff, p1_dy_ff, p2_dx_ff, p2_dy_ff;
   logic signed [DIST_W-1:0]   p1_dist_in, p1_dist_ff, p2_dist_ff;
   front_tag_type              p1_tag_ff, p2_tag_ff;
   logic [FRAC_W:0]            span_x, span_y;
   logic [FP_W-1:0]            p2_fx_in, p2_fy_in, p2_fx_ff, p2_fy_ff;
   logic signed [TP_W-1:0]     p2_tp_in, p2_tp_ff;
   logic                       xside, mirror;
   logic [FRAC_W-1:0]          pother, frac_hit, tex_raw, tex_mir;
   logic [2*FRAC_W-1:0]        tex_prod;
   back_tag_type               p3_tag_in, p3_tag_ff;
   logic [DIV_D_W-1:0]         p3_dvs_ff;

   always_comb begin
      p1_dx_in = in_tag.zero_x ? '1 : in_quot_x[DIST_W-1:0];
      p1_dy_in = in_tag.zero_y ? '1 : in_quot_y[DIST_W-1:0];
      priority if (in_tag.zero_main) begin
         p1_dist_in = 32'sh7FFF_FFFF;
      end else if (in_tag.quot_neg) begin
         if (in_quot_dist > DIV_N_W'(64'h8000_0000)) begin
            p1_dist_in = 32'sh8000_0000;
         end else begin
            p1_dist_in = -$signed(in_quot_dist[DIST_W-1:0]);
         end
      end else if (in_quot_dist > DIV_N_W'(64'h7FFF_FFFF)) begin
         p1_dist_in = 32'sh7FFF_FFFF;
      end else begin
         p1_dist_in = $signed(in_quot_dist[DIST_W-1:0]);
      end
   end

   assign span_x   = p1_tag_ff.neg_x ? {1'b0, cfg.pos_x[FRAC_W-1:0]}
                                     : 17'h10000 - {1'b0, cfg.pos_x[FRAC_W-1:0]};
   assign span_y   = p1_tag_ff.neg_y ? {1'b0, cfg.pos_y[FRAC_W-1:0]}
                                     : 17'h10000 - {1'b0, cfg.pos_y[FRAC_W-1:0]};
   assign p2_fx_in = FP_W'(span_x) * FP_W'(p1_dx_ff);
   assign p2_fy_in = FP_W'(span_y) * FP_W'(p1_dy_ff);
   assign p2_tp_in = TP_W'(p1_dist_ff) * TP_W'(p1_tag_ff.ray_other);

   always_comb begin
      xside    = (p2_tag_ff.side == SIDE_EAST) || (p2_tag_ff.side == SIDE_WEST);
      mirror   = (p2_tag_ff.side == SIDE_SOUTH) || (p2_tag_ff.side == SIDE_WEST);
      pother   = xside ? cfg.pos_y[FRAC_W-1:0] : cfg.pos_x[FRAC_W-1:0];
      frac_hit = pother + p2_tp_ff[FRAC_W+13:14];
      tex_prod = (2*FRAC_W)'(frac_hit) * (2*FRAC_W)'(TEXTURE_WIDTH);
      tex_raw  = tex_prod[2*FRAC_W-1:FRAC_W];
      tex_mir  = FRAC_W'(TEXTURE_WIDTH - 1) - tex_raw;

      p3_tag_in.neg_x       = p2_tag_ff.neg_x;
      p3_tag_in.neg_y       = p2_tag_ff.neg_y;
      p3_tag_in.delta_x     = p2_dx_ff;
      p3_tag_in.delta_y     = p2_dy_ff;
      p3_tag_in.first_x     = (p2_tag_ff.zero_x || p2_fx_ff[FP_W-1]) ? '1
                              : p2_fx_ff[FP_W-2:FRAC_W];
      p3_tag_in.first_y     = (p2_tag_ff.zero_y || p2_fy_ff[FP_W-1]) ? '1
                              : p2_fy_ff[FP_W-2:FRAC_W];
      p3_tag_in.wall_dist   = p2_dist_ff;
      p3_tag_in.height_max  = (p2_dist_ff == '0);
      p3_tag_in.height_zero = p2_dist_ff[DIST_W-1];
      p3_tag_in.tex         = mirror ? tex_mir[TEX_W-1:0] : tex_raw[TEX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_dx_ff   <= p1_dx_in;
         p1_dy_ff   <= p1_dy_in;
         p1_dist_ff <= p1_dist_in;
         p1_tag_ff  <= in_tag;
         p2_fx_ff   <= p2_fx_in;
         p2_fy_ff   <= p2_fy_in;
         p2_tp_ff   <= p2_tp_in;
         p2_dx_ff   <= p1_dx_ff;
         p2_dy_ff   <= p1_dy_ff;
         p2_dist_ff <= p1_dist_ff;
         p2_tag_ff  <= p1_tag_ff;
         p3_tag_ff  <= p3_tag_in;
         p3_dvs_ff  <= DIV_D_W'(p2_dist_ff);
      end
   end

   assign out_valid   = valid_ff[2];
   assign out_divisor = p3_dvs_ff;
   assign out_tag     = p3_tag_ff;

endmodule

[rtl/raycast_column_projector_core.sv]
// An accepted request transaction reaches its response through two chained 40-stage
// dividers (4 ray, 40, 3 post, 40, 1 output).
// Throughput: one transaction per cycle; the pipeline holds as a whole while
// a response waits on rsp_ready.
// Reset: synchronous, clears all valid bits and loads the configuration
// defaults (direction +x, camera plane about 0.66 in y, position zero).
`timescale 1ns / 1ps
module raycast_column_projector_core import rcp_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [COL_W-1:0]            req_screen_column,
   input  logic [CELL_W-1:0]           req_hit_cell_x,
   input  logic [CELL_W-1:0]           req_hit_cell_y,
   input  logic [SIDE_W-1:0]           req_hit_side,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_step_x_negative,
   output logic                        rsp_step_y_negative,
   output logic [DIST_W-1:0]           rsp_delta_dist_x,
   output logic [DIST_W-1:0]           rsp_delta_dist_y,
   output logic [DIST_W-1:0]           rsp_first_dist_x,
   output logic [DIST_W-1:0]           rsp_first_dist_y,
   output logic signed [DIST_W-1:0]    rsp_wall_distance,
   output logic [HEIGHT_W-1:0]         rsp_wall_height,
   output logic signed [ROW_W-1:0]     rsp_wall_top_row,
   output logic signed [ROW_W-1:0]     rsp_wall_bottom_row,
   output logic [TEX_W-1:0]            rsp_texture_column,
   input  logic                        csr_wen,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]            csr_wdata
);

   cfg_type            cfg_ff, cfg_in;
   logic               advance;
   logic               ray_valid, post_valid, hdiv_valid, dist_valid;
   ray_out_type        ray_out;
   logic [DIV_N_W-1:0] quot_x, quot_y, quot_dist, quot_h;
   div_tag_type        dist_tag, hdiv_tag;
   logic [DIV_D_W-1:0] h_divisor;
   back_tag_type       post_tag, fin_tag;
   logic [HEIGHT_W-1:0] height;
   logic signed [ROW_W+1:0] top_full, bot_full;
   logic               out_valid_ff;
   back_tag_type       out_tag_ff;
   logic [HEIGHT_W-1:0] out_height_ff;
   logic signed [ROW_W-1:0] out_top_ff, out_bot_ff, out_top_in, out_bot_in;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_POS_X:   cfg_in.pos_x   = csr_wdata;
            REG_POS_Y:   cfg_in.pos_y   = csr_wdata;
            REG_DIR_X:   cfg_in.dir_x   = $signed(csr_wdata[DIR_W-1:0]);
            REG_DIR_Y:   cfg_in.dir_y   = $signed(csr_wdata[DIR_W-1:0]);
            REG_PLANE_X: cfg_in.plane_x = $signed(csr_wdata[DIR_W-1:0]);
            REG_PLANE_Y: cfg_in.plane_y = $signed(csr_wdata[DIR_W-1:0]);
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_x   <= '0;
         cfg_ff.pos_y   <= '0;
         cfg_ff.dir_x   <= 16'sd16384;
         cfg_ff.dir_y   <= '0;
         cfg_ff.plane_x <= '0;
         cfg_ff.plane_y <= 16'sd10813;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rcp_ray u_ray (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_col    (req_screen_column),
      .in_cell_x (req_hit_cell_x),
      .in_cell_y (req_hit_cell_y),
      .in_side   (req_hit_side),
      .out_valid (ray_valid),
      .out_ray   (ray_out)
   );

   rcp_div u_div_x (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (ray_valid),
      .in_dividend  (DELTA_NUM),
      .in_divisor   (DIV_D_W'(ray_out.abs_x)),
      .in_tag       ('0),
      .out_valid    (),
      .out_quotient (quot_x),
      .out_tag      ()
   );

   rcp_div u_div_y (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (ray_valid),
      .in_dividend  (DELTA_NUM),
      .in_divisor   (DIV_D_W'(ray_out.abs_y)),
      .in_tag       ('0),
      .out_valid    (),
      .out_quotient (quot_y),
      .out_tag      ()
   );

   rcp_div u_div_dist (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (ray_valid),
      .in_dividend  (ray_out.num_mag),
      .in_divisor   (DIV_D_W'(ray_out.main_mag)),
      .in_tag       (DIV_TAG_W'(ray_out.tag)),
      .out_valid    (dist_valid),
      .out_quotient (quot_dist),
      .out_tag      (dist_tag)
   );

   rcp_post u_post (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .cfg          (cfg_ff),
      .in_valid     (dist_valid),
      .in_quot_x    (quot_x),
      .in_quot_y    (quot_y),
      .in_quot_dist (quot_dist),
      .in_tag       (front_tag_type'(dist_tag[$bits(front_tag_type)-1:0])),
      .out_valid    (post_valid),
      .out_divisor  (h_divisor),
      .out_tag      (post_tag)
   );

   rcp_div u_div_height (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (post_valid),
      .in_dividend  (HEIGHT_NUM),
      .in_divisor   (h_divisor),
      .in_tag       (div_tag_type'(post_tag)),
      .out_valid    (hdiv_valid),
      .out_quotient (quot_h),
      .out_tag      (hdiv_tag)
   );

   always_comb begin
      fin_tag = back_tag_type'(hdiv_tag);
      priority if (fin_tag.height_zero) begin
         height = '0;
      end else if (fin_tag.height_max || (quot_h > DIV_N_W'(16'hFFFF))) begin
         height = '1;
      end else begin
         height = quot_h[HEIGHT_W-1:0];
      end
      top_full = $signed((ROW_W+2)'(SCREEN_HEIGHT / 2)) - $signed((ROW_W+2)'(height >> 1));
      bot_full = $signed((ROW_W+2)'(SCREEN_HEIGHT / 2)) + $signed((ROW_W+2)'(height >> 1));
      priority if (top_full < -$signed((ROW_W+2)'(32768))) begin
         out_top_in = 16'sh8000;
      end else if (top_full > $signed((ROW_W+2)'(32767))) begin
         out_top_in = 16'sh7FFF;
      end else begin
         out_top_in = top_full[ROW_W-1:0];
      end
      priority if (bot_full > $signed((ROW_W+2)'(32767))) begin
         out_bot_in = 16'sh7FFF;
      end else begin
         out_bot_in = bot_full[ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= hdiv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_tag_ff    <= fin_tag;
         out_height_ff <= height;
         out_top_ff    <= out_top_in;
         out_bot_ff    <= out_bot_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_step_x_negative = out_tag_ff.neg_x;
   assign rsp_step_y_negative = out_tag_ff.neg_y;
   assign rsp_delta_dist_x    = out_tag_ff.delta_x;
   assign rsp_delta_dist_y    = out_tag_ff.delta_y;
   assign rsp_first_dist_x    = out_tag_ff.first_x;
   assign rsp_first_dist_y    = out_tag_ff.first_y;
   assign rsp_wall_distance   = out_tag_ff.wall_dist;
   assign rsp_wall_height     = out_height_ff;
   assign rsp_wall_top_row    = out_top_ff;
   assign rsp_wall_bottom_row = out_bot_ff;
   assign rsp_texture_column  = out_tag_ff.tex;

endmodule
